// ===== src/assert_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SITDA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SITDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/sitda_pkg.sv =====
// Package: shared types, character codes and sizing helper for the decimal text converter.
`default_nettype none

package sitda_pkg;

  // ASCII codes
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  // Double dabble correction: digits of five or more get three added before the shift
  localparam logic [3:0] ADJ_MIN = 4'd5;
  localparam logic [3:0] ADJ_ADD = 4'd3;

  // Status of the binary-to-BCD unit
  typedef struct packed {
    logic busy;
    logic done;
  } dab_stat_t;

  // Command to the character emitter
  typedef struct packed {
    logic start;
    logic negative;
  } emit_cmd_t;

  // Decimal digits needed for a magnitude of the given bit width
  function automatic int max_digits(input int width);
    return (width * 30103) / 100000 + 1;
  endfunction

endpackage

`default_nettype wire

// ===== src/signed_int_to_decimal_ascii.sv =====
// Flow: after the accept edge the serial BCD loop runs one shift-add-3 step per
// magnitude bit, the emitter then skips leading zeros and sends one character per cycle
// while m_tready is high. A new number is taken only once the last character is out.
// s_tready stays low from accept until the last character is taken.
// Reset: synchronous, active high; returns to idle with no character pending.
`default_nettype none

module signed_int_to_decimal_ascii
  import sitda_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [((VALUE_WIDTH + 7) / 8)*8-1:0] s_tdata,   // value [VALUE_WIDTH-1:0]
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic      [7:0]                           m_tdata,   // char_code [7:0]
  output logic                                      m_tlast    // last_char
);

  localparam int MAX_DIGITS = max_digits(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0]  value;
  logic [VALUE_WIDTH-1:0]  magnitude;
  logic                    accept;
  logic                    negative;
  logic [MAX_DIGITS*4-1:0] digits;
  dab_stat_t               dab_stat;
  emit_cmd_t               emit_cmd;
  logic                    emit_busy;

  // magnitude formed as unsigned, so the most negative value stays exact
  assign value     = s_tdata[VALUE_WIDTH-1:0];
  assign magnitude = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

  assign s_tready = !dab_stat.busy && !dab_stat.done && !emit_busy;
  assign accept   = s_tvalid && s_tready;

  // sign held while the BCD unit runs
  always_ff @(posedge clk) begin
    if (rst) begin
      negative <= 1'b0;
    end else if (accept) begin
      negative <= value[VALUE_WIDTH-1];
    end
  end

  assign emit_cmd.start    = dab_stat.done;
  assign emit_cmd.negative = negative;

  sitda_dabble #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_dabble (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .magnitude (magnitude),
    .stat      (dab_stat),
    .digits    (digits)
  );

  sitda_emit #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_emit (
    .clk      (clk),
    .rst      (rst),
    .cmd      (emit_cmd),
    .digits   (digits),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .busy     (emit_busy)
  );

endmodule

`default_nettype wire

// ===== src/sitda_dabble.sv =====
// Iterative binary-to-BCD unit: one shift-add-3 step per cycle over the magnitude bits.
`default_nettype none

module sitda_dabble
  import sitda_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 10
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [VALUE_WIDTH-1:0]    magnitude,
  output dab_stat_t                      stat,
  output logic      [MAX_DIGITS*4-1:0]   digits
);

  localparam int DIG_W = MAX_DIGITS * 4;
  localparam int CW    = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] magnitude_work;
  logic [CW-1:0]          cnt;
  logic [DIG_W-1:0]       adj;
  logic                   busy;
  logic                   done;

  // add-3 correction on every digit lane
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i*4 +: 4] = (digits[i*4 +: 4] >= ADJ_MIN) ? digits[i*4 +: 4] + ADJ_ADD
                                                    : digits[i*4 +: 4];
    end
  end

  // sequencer: load, then shift one magnitude bit into the BCD register per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy           <= 1'b1;
        cnt            <= CW'(VALUE_WIDTH);
        magnitude_work <= magnitude;
        digits         <= '0;
      end else if (busy) begin
        digits         <= {adj[DIG_W-2:0], magnitude_work[VALUE_WIDTH-1]};
        magnitude_work <= {magnitude_work[VALUE_WIDTH-2:0], 1'b0};
        cnt            <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// ===== src/sitda_emit.sv =====
// Character emitter: skips leading zeros, then sends sign and digits through an output register.
`default_nettype none

module sitda_emit
  import sitda_pkg::*;
#(
  parameter int MAX_DIGITS = 10
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire emit_cmd_t               cmd,
  input  wire logic [MAX_DIGITS*4-1:0] digits,
  input  wire logic                    m_tready,
  output logic                         m_tvalid,
  output logic      [7:0]              m_tdata,   // char_code [7:0]
  output logic                         m_tlast,   // last_char
  output logic                         busy
);

  localparam int PW = $clog2(MAX_DIGITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT,
    S_DRAIN
  } state_t;

  state_t        state;
  logic [PW-1:0] emit_pointer;
  logic          sign_pending;
  logic [3:0]    cur_digit;
  logic          out_free;

  assign cur_digit = digits[emit_pointer*4 +: 4];
  assign out_free  = !m_tvalid || m_tready;
  assign busy      = (state != S_IDLE);

  // state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      m_tvalid     <= 1'b0;
      sign_pending <= 1'b0;
      emit_pointer <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.start) begin
            sign_pending <= cmd.negative;
            emit_pointer <= PW'(MAX_DIGITS - 1);
            state        <= S_SCAN;
          end
        end
        // one leading zero dropped per cycle; the units digit always stays
        S_SCAN: begin
          if (cur_digit == 4'd0 && emit_pointer != '0) begin
            emit_pointer <= emit_pointer - 1'b1;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (sign_pending) begin
              m_tdata      <= CHAR_MINUS;
              m_tlast      <= 1'b0;
              sign_pending <= 1'b0;
            end else begin
              m_tdata <= CHAR_ZERO + {4'd0, cur_digit};
              m_tlast <= (emit_pointer == '0);
              if (emit_pointer == '0) begin
                state <= S_DRAIN;
              end else begin
                emit_pointer <= emit_pointer - 1'b1;
              end
            end
          end
        end
        // hold until the final character is taken
        S_DRAIN: begin
          if (out_free) begin
            m_tvalid <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/sitda_checker.sv =====
// Port-level checker for the decimal text converter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module sitda_checker
  import sitda_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast
);

  // a stalled character holds
  `SITDA_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled character changed")

  // no new number taken while characters are still going out
  `SITDA_ASSERT(a_no_overlap, clk, rst, !(s_tready && m_tvalid), "input ready while output pending")

  // conversion takes time: nothing comes out right after accept
  `SITDA_ASSERT_NEXT(a_accept_quiet, clk, rst, s_tvalid && s_tready, !m_tvalid, "character right after accept")

  // only minus sign and digit codes appear
  `SITDA_ASSERT(a_char_set, clk, rst, !m_tvalid || m_tdata == CHAR_MINUS || (m_tdata >= CHAR_ZERO && m_tdata <= CHAR_NINE), "bad character code")

  // the minus sign never ends a number
  `SITDA_ASSERT(a_sign_not_last, clk, rst, !(m_tvalid && m_tdata == CHAR_MINUS && m_tlast), "minus sign flagged last")

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== bench/signed_int_to_decimal_ascii_check.sv =====
// Checker for the decimal text converter: predicts the character stream and compares it.
module signed_int_to_decimal_ascii_check
  import sitda_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // value [31:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // char_code [7:0]
  input  logic        m_tlast,   // last_char
  output int          fail_count,
  output int          chars_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  // Characters still owed by the block, oldest first
  text_char_t text_due [$];

  initial begin
    fail_count = 0;
    chars_due  = 0;
  end

  // Append the decimal text of one request to the owed characters
  function automatic void queue_decimal_text(input logic [31:0] value);
    logic [31:0] mag;
    logic [3:0]  digits [10];
    int          count;
    text_char_t  ch;
    // two's complement negate in 32 bits keeps the most negative value exact
    mag   = value[31] ? (~value + 32'd1) : value;
    count = 0;
    do begin
      digits[count] = 4'(mag % 32'd10);
      count++;
      mag = mag / 32'd10;
    end while (mag != 32'd0);
    if (value[31]) begin
      ch.code = CHAR_MINUS;
      ch.last = 1'b0;
      text_due.push_back(ch);
    end
    for (int i = count - 1; i >= 0; i--) begin
      ch.code = CHAR_ZERO + 8'(digits[i]);
      ch.last = (i == 0);
      text_due.push_back(ch);
    end
  endfunction

  // Watch both channels on every edge
  always @(posedge clk) begin
    text_char_t want;
    logic       bad;
    bad = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready)
        queue_decimal_text(s_tdata);
      if (m_tvalid && m_tready) begin
        if (text_due.size() == 0) begin
          bad = 1'b1;
          if (fail_count < 10)
            $display("%0t: unexpected char code=%0d last=%0b", $realtime, m_tdata, m_tlast);
        end else begin
          want = text_due.pop_front();
          if (m_tdata !== want.code) begin
            bad = 1'b1;
            if (fail_count < 10)
              $display("%0t: char_code expected %0d got %0d", $realtime, want.code, m_tdata);
          end
          if (m_tlast !== want.last) begin
            bad = 1'b1;
            if (fail_count < 10)
              $display("%0t: last_char expected %0b got %0b", $realtime, want.last, m_tlast);
          end
        end
      end
    end
    if (bad)
      fail_count <= fail_count + 1;
    chars_due <= text_due.size();
  end

endmodule

// ===== bench/signed_int_to_decimal_ascii_test.sv =====
// Top of the testbench: clock, reset, request stimulus, output back-pressure and verdict.
module signed_int_to_decimal_ascii_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 86;
  localparam int SETTLE       = 64;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  int          fail_count;
  int          chars_due;
  int          cycles = 0;
  bit          steady = 1'b0;

  always #6 clk = ~clk;

  signed_int_to_decimal_ascii #(.VALUE_WIDTH(32)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  signed_int_to_decimal_ascii_check i_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .chars_due  (chars_due)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Wait until every owed character has come out
  task automatic wait_drained();
    do @(posedge clk); while (chars_due != 0);
  endtask

  // Offer one request; valid only drops when a gap or a drain comes first
  task automatic send_value(input logic [31:0] value, input bit drain);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 19);
    if (gap > 0 || drain)
      s_tvalid <= 1'b0;
    if (drain)
      wait_drained();
    repeat (gap) @(posedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
  endtask

  // Random value, weighted toward digit-count boundaries and small numbers
  function automatic logic [31:0] pick_value();
    logic [31:0] scale;
    logic [31:0] value;
    int          n;
    n     = $urandom_range(0, 9);
    scale = 32'd1;
    repeat (n) scale = scale * 32'd10;
    case ($urandom_range(0, 3))
      0: value = $urandom();
      1: value = $urandom_range(scale * 32'd10 - 32'd1, 32'd0);
      2: value = 32'($urandom_range(0, 40)) - 32'd20;
      default: value = scale - 32'd1 + 32'($urandom_range(0, 2));
    endcase
    if ($urandom_range(0, 1) == 1)
      value = ~value + 32'd1;
    return value;
  endfunction

  // Result side: random stalls per character, none during steady stretches
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Stimulus and verdict
  initial begin
    int directed_values [$];
    directed_values = {0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -67890,
                       999999999, 1000000000, -999999999, -1000000000,
                       2147483647, -2147483647, 32'h8000_0000, 1234567890,
                       -1234567891, 32'h5555_5555, 32'hAAAA_AAAA};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_values[k])
      send_value(directed_values[k], 1'b0);

    // Let the block run dry once before the random part
    send_value(pick_value(), 1'b1);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      steady = (k >= 50 && k < 70);
      send_value(pick_value(), k == 80);
    end
    steady = 1'b0;

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);

    if (fail_count == 0 && chars_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
